### hw/rtl/wfmc_pkg.sv
// Shared types, constants and register codes for the wall follow mode controller.
package wfmc_pkg;

    // Range path width; the 16-bit range ports are masked down to it.
    localparam int DIST_BITS = 16;
    localparam int IN_BITS   = (DIST_BITS < 16) ? DIST_BITS : 16;
    localparam int FRAC_SHIFT = 16;
    localparam int PROD_BITS  = DIST_BITS + FRAC_SHIFT;

    localparam int WALL_BITS  = 12;
    localparam int TOL_BITS   = 10;
    localparam int SPEED_BITS = 10;
    localparam int RATE_BITS  = 13;
    localparam int ANG_BITS   = 14;
    localparam int IDX_BITS   = 8;
    localparam int CFG_BITS   = 16;

    // cos(45 deg) in 0.16 fixed point
    localparam logic [FRAC_SHIFT-1:0] DIAG_NUM = 16'd46341;
    // floor(w/10) == (w*3277) >> 15 for every 12-bit w
    localparam logic [WALL_BITS-1:0] RECIP_10 = 12'd3277;
    localparam int RECIP_SHIFT = 15;
    localparam logic [WALL_BITS-1:0] HOLD_MARGIN_MM = 12'd100;

    typedef logic [DIST_BITS-1:0]  dist_t;
    typedef logic [WALL_BITS-1:0]  wall_t;
    typedef logic [TOL_BITS-1:0]   tol_t;
    typedef logic [SPEED_BITS-1:0] speed_t;
    typedef logic [RATE_BITS-1:0]  rate_t;
    typedef logic signed [ANG_BITS-1:0] ang_t;
    typedef logic [1:0] mode_t;

    localparam mode_t MODE_APPROACH = 2'd0;
    localparam mode_t MODE_ROTATE   = 2'd1;
    localparam mode_t MODE_FOLLOW   = 2'd2;
    localparam mode_t MODE_CORNER   = 2'd3;

    localparam logic [IDX_BITS-1:0] REG_WALL_DISTANCE = 8'd0;
    localparam logic [IDX_BITS-1:0] REG_ALIGN_TOL     = 8'd1;
    localparam logic [IDX_BITS-1:0] REG_CRUISE_SPEED  = 8'd2;
    localparam logic [IDX_BITS-1:0] REG_TURN_RATE     = 8'd3;

    typedef struct packed {
        wall_t  wall_distance;
        tol_t   align_tol;
        speed_t cruise_speed;
        rate_t  turn_rate;
    } cfg_t;

    typedef struct packed {
        dist_t front;
        dist_t slant;
        dist_t right;
        dist_t back;
    } scan_t;

    typedef struct packed {
        mode_t  mode_next;
        dist_t  back_mark_next;
        speed_t speed;
        ang_t   angular;
    } step_t;

endpackage

### hw/rtl/wall_follow_mode_controller.sv
// Top level of the wall follow mode controller: handshakes, registers and mode state.
//
// Usage:
//   Scan channel (in_valid/in_ready): one transfer per scan tick with the front,
//   front-right, right and back ranges in mm. Command channel (out_valid/out_ready):
//   one transfer per tick with linear_speed, angular_rate and mode_after.
//   Config channel (cfg_valid/cfg_ready): cfg_ready is always high; indexes 0..3
//   select wall distance, alignment tolerance, cruise speed and turn rate, other
//   indexes are dropped. Write only while no tick is in flight.
//   Path: a tick is captured into the input register, then the mode logic and its
//   single diagonal multiply run combinationally into the result register, which
//   drives the command outputs.
//   Throughput: one tick per cycle unless out_ready stalls, as the mode loop closes through one register.
//   Stall: while out_ready is low the result is held; one further tick can wait
//   in the input register, after which in_ready drops.
//   Reset: mode returns to approach, the stored back mark clears, registers take
//   their defaults (500, 50, 200, 500) and both pipeline stages empty.
module wall_follow_mode_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [15:0]                     front_mm,
    input  logic [15:0]                     front_right_mm,
    input  logic [15:0]                     right_mm,
    input  logic [15:0]                     back_mm,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [wfmc_pkg::SPEED_BITS-1:0] linear_speed,
    output logic signed [wfmc_pkg::ANG_BITS-1:0] angular_rate,
    output logic [1:0]                      mode_after,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wfmc_pkg::IDX_BITS-1:0]   cfg_index,
    input  logic [wfmc_pkg::CFG_BITS-1:0]   cfg_data
);
    import wfmc_pkg::*;

    cfg_t   cfg_reg;
    scan_t  scan_reg;
    logic   in_valid_reg;
    logic   out_valid_reg;
    mode_t  mode_reg;
    dist_t  back_mark_reg;
    speed_t speed_reg;
    ang_t   ang_reg;
    step_t  step;
    logic   advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_valid_reg;
    assign linear_speed = speed_reg;
    assign angular_rate = ang_reg;
    assign mode_after   = mode_reg;

    wfmc_step u_step (
        .cfg       (cfg_reg),
        .scan      (scan_reg),
        .mode      (mode_reg),
        .back_mark (back_mark_reg),
        .res       (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wall_distance <= wall_t'(500);
            cfg_reg.align_tol     <= tol_t'(50);
            cfg_reg.cruise_speed  <= speed_t'(200);
            cfg_reg.turn_rate     <= rate_t'(500);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WALL_DISTANCE: cfg_reg.wall_distance <= cfg_data[WALL_BITS-1:0];
                REG_ALIGN_TOL:     cfg_reg.align_tol     <= cfg_data[TOL_BITS-1:0];
                REG_CRUISE_SPEED:  cfg_reg.cruise_speed  <= cfg_data[SPEED_BITS-1:0];
                REG_TURN_RATE:     cfg_reg.turn_rate     <= cfg_data[RATE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_APPROACH;
            back_mark_reg <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= step.mode_next;
                back_mark_reg <= step.back_mark_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            scan_reg.front <= dist_t'(front_mm[IN_BITS-1:0]);
            scan_reg.slant <= dist_t'(front_right_mm[IN_BITS-1:0]);
            scan_reg.right <= dist_t'(right_mm[IN_BITS-1:0]);
            scan_reg.back  <= dist_t'(back_mm[IN_BITS-1:0]);
        end
        if (advance)
        begin
            speed_reg <= step.speed;
            ang_reg   <= step.angular;
        end
    end

`ifndef NO_ASSERTIONS
    // a stored back mark only lives inside the corner mode
    a_mark_in_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (back_mark_reg != '0) |-> (mode_reg == MODE_CORNER))
        else $error("back mark set outside corner mode");

    // a tick that changes mode commands no motion
    a_transition_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (step.mode_next != mode_reg))
        |=> (linear_speed == '0) && (angular_rate == '0))
        else $error("mode transition with nonzero command");

    // only the rotate mode turns left
    a_left_only_rotate: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (mode_reg != MODE_ROTATE)) |=> !(angular_rate > 0))
        else $error("left turn outside rotate mode");

    // never drive and turn at the same time
    a_speed_or_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (linear_speed != '0)) |-> (angular_rate == '0))
        else $error("speed and turn commanded together");

    // a held tick in the input stage is not lost
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(scan_reg))
        else $error("stalled input tick dropped");
`endif

endmodule

### hw/rtl/wfmc_step.sv
// Mode decision and motion command for one scan tick.
module wfmc_step (
    input  wfmc_pkg::cfg_t  cfg,
    input  wfmc_pkg::scan_t scan,
    input  wfmc_pkg::mode_t mode,
    input  wfmc_pkg::dist_t back_mark,
    output wfmc_pkg::step_t res
);
    import wfmc_pkg::*;

    localparam int CMP_BITS = DIST_BITS + 1;

    logic [PROD_BITS-1:0]   diag_scaled;
    logic [PROD_BITS-1:0]   right_scaled;
    logic [PROD_BITS-1:0]   tol_scaled;
    logic [PROD_BITS-1:0]   wall_scaled;
    logic [PROD_BITS-1:0]   align_err;
    logic [2*WALL_BITS-1:0] recip_prod;
    logic [CMP_BITS-1:0]    corner_thresh;
    logic [CMP_BITS-1:0]    right_ext;
    dist_t                  wall_dist;
    dist_t                  back_err;
    dist_t                  hold_thresh;
    logic                   front_close;
    logic                   front_clear;
    logic                   hold;
    logic                   speed_en;
    logic                   turn_left;
    logic                   turn_right;

    always_comb
    begin
        diag_scaled  = PROD_BITS'(scan.slant) * PROD_BITS'(DIAG_NUM);
        right_scaled = PROD_BITS'(scan.right) << FRAC_SHIFT;
        tol_scaled   = PROD_BITS'(cfg.align_tol) << FRAC_SHIFT;
        wall_scaled  = PROD_BITS'(cfg.wall_distance) << FRAC_SHIFT;
        align_err    = (diag_scaled > right_scaled) ? diag_scaled - right_scaled
                                                    : right_scaled - diag_scaled;

        recip_prod    = (2*WALL_BITS)'(cfg.wall_distance) * (2*WALL_BITS)'(RECIP_10);
        corner_thresh = CMP_BITS'(cfg.wall_distance)
                      + CMP_BITS'(recip_prod >> RECIP_SHIFT);
        right_ext     = CMP_BITS'(scan.right);

        wall_dist   = dist_t'(cfg.wall_distance);
        front_close = scan.front <= wall_dist;
        front_clear = scan.front >= wall_dist;

        back_err    = (scan.back > back_mark) ? scan.back - back_mark
                                              : back_mark - scan.back;
        hold_thresh = dist_t'(cfg.wall_distance - HOLD_MARGIN_MM);
        hold        = (back_mark != '0) && (cfg.wall_distance > HOLD_MARGIN_MM)
                   && (back_err < hold_thresh);

        res.mode_next      = mode;
        res.back_mark_next = back_mark;
        speed_en   = 1'b0;
        turn_left  = 1'b0;
        turn_right = 1'b0;

        case (mode)
            MODE_APPROACH:
            begin
                if (front_close)
                    res.mode_next = MODE_ROTATE;
                else
                    speed_en = 1'b1;
            end
            MODE_ROTATE:
            begin
                if ((align_err < tol_scaled) && front_clear)
                    res.mode_next = MODE_FOLLOW;
                else
                    turn_left = 1'b1;
            end
            MODE_FOLLOW:
            begin
                if (front_close)
                    res.mode_next = MODE_ROTATE;
                else if (right_ext > corner_thresh)
                begin
                    res.back_mark_next = scan.back;
                    res.mode_next      = MODE_CORNER;
                end
                else
                    speed_en = 1'b1;
            end
            default:
            begin
                if (hold)
                    speed_en = 1'b1;
                else
                begin
                    res.back_mark_next = '0;
                    if (diag_scaled > wall_scaled)
                        turn_right = 1'b1;
                    else if (scan.right > wall_dist)
                        speed_en = 1'b1;
                    else
                        res.mode_next = MODE_FOLLOW;
                end
            end
        endcase

        res.speed = speed_en ? cfg.cruise_speed : '0;
        if (turn_left)
            res.angular = ang_t'(cfg.turn_rate);
        else if (turn_right)
            res.angular = -ang_t'(cfg.turn_rate);
        else
            res.angular = '0;
    end

endmodule

### tb/wall_follow_mode_controller_tb.sv
// Self-checking testbench for the wall follow mode controller: directed table, then random scans.
module wall_follow_mode_controller_tb;
    import wfmc_pkg::*;

    localparam int STALL_LIMIT     = 400;
    localparam int PHASES          = 16;
    localparam int SCANS_PER_PHASE = 102;
    localparam int N_ROWS          = 23;
    localparam int MAX_REPORTS     = 100;

    typedef struct packed {
        speed_t speed;
        ang_t   angular;
        mode_t  mode;
    } cmd_t;

    typedef struct packed {
        scan_t scan;
        logic  typed;
        cmd_t  want;
    } row_t;

    // Typed rows assume the reset register values (W 500, T 50, speed 200, rate 500).
    localparam row_t ROWS [N_ROWS] = '{
        '{'{16'd65535, 16'd0, 16'd0, 16'd0}, 1'b1, '{10'd200, 14'sd0, MODE_APPROACH}},
        '{'{16'd500, 16'd65535, 16'd65535, 16'd65535}, 1'b1, '{10'd0, 14'sd0, MODE_ROTATE}},
        '{'{16'd65535, 16'd0, 16'd65535, 16'd0}, 1'b1, '{10'd0, 14'sd500, MODE_ROTATE}},
        '{'{16'd499, 16'd0, 16'd0, 16'd0}, 1'b1, '{10'd0, 14'sd500, MODE_ROTATE}},
        '{'{16'd500, 16'd0, 16'd0, 16'd0}, 1'b1, '{10'd0, 14'sd0, MODE_FOLLOW}},
        '{'{16'd600, 16'd0, 16'd550, 16'd0}, 1'b1, '{10'd200, 14'sd0, MODE_FOLLOW}},
        '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{10'd0, 14'sd0, MODE_ROTATE}},
        '{'{16'd65535, 16'd1000, 16'd707, 16'd0}, 1'b0, '0},
        '{'{16'd65535, 16'd0, 16'd551, 16'd1000}, 1'b1, '{10'd0, 14'sd0, MODE_CORNER}},
        '{'{16'd0, 16'd0, 16'd0, 16'd1300}, 1'b0, '0},
        '{'{16'd0, 16'd65535, 16'd0, 16'd1400}, 1'b1, '{10'd0, -14'sd500, MODE_CORNER}},
        '{'{16'd0, 16'd0, 16'd501, 16'd1000}, 1'b0, '0},
        '{'{16'd65535, 16'd0, 16'd500, 16'd0}, 1'b1, '{10'd0, 14'sd0, MODE_FOLLOW}},
        // zero back range stored as the mark, so the corner hold cannot apply
        '{'{16'd65535, 16'd0, 16'd65535, 16'd0}, 1'b1, '{10'd0, 14'sd0, MODE_CORNER}},
        '{'{16'd65535, 16'd708, 16'd0, 16'd0}, 1'b0, '0},
        '{'{16'd65535, 16'd707, 16'd65535, 16'd0}, 1'b0, '0},
        '{'{16'd65535, 16'd0, 16'd0, 16'd65535}, 1'b1, '{10'd0, 14'sd0, MODE_FOLLOW}},
        '{'{16'd501, 16'd65535, 16'd0, 16'd65535}, 1'b0, '0},
        '{'{16'd500, 16'd0, 16'd0, 16'd0}, 1'b1, '{10'd0, 14'sd0, MODE_ROTATE}},
        // alignment error exactly at the tolerance, then one below it
        '{'{16'd500, 16'd0, 16'd50, 16'd0}, 1'b0, '0},
        '{'{16'd500, 16'd0, 16'd49, 16'd0}, 1'b0, '0},
        '{'{16'd65535, 16'd65535, 16'd65535, 16'd65535}, 1'b0, '0},
        '{'{16'd65535, 16'd65535, 16'd65535, 16'd0}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [15:0] front_mm = '0;
    logic [15:0] front_right_mm = '0;
    logic [15:0] right_mm = '0;
    logic [15:0] back_mm = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    speed_t linear_speed;
    ang_t angular_rate;
    logic [1:0] mode_after;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    // controller model state and register copies
    mode_t  ctl_mode = MODE_APPROACH;
    dist_t  back_mark = '0;
    wall_t  wall_dist = 12'd500;
    tol_t   align_tol = 10'd50;
    speed_t cruise = 10'd200;
    rate_t  turn_rt = 13'd500;

    cmd_t cmd_fifo [$];
    int   mismatches = 0;
    int   quiet_cycles = 0;
    int   out_hold = 0;
    bit   idle_in = 1'b1;
    bit   idle_out = 1'b1;

    wall_follow_mode_controller u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .front_mm       (front_mm),
        .front_right_mm (front_right_mm),
        .right_mm       (right_mm),
        .back_mm        (back_mm),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .linear_speed   (linear_speed),
        .angular_rate   (angular_rate),
        .mode_after     (mode_after),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    function automatic logic [47:0] abs_gap(input logic [47:0] a, input logic [47:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // One scan tick through the mode machine; updates mode and back mark.
    function automatic cmd_t steer_step(input scan_t s);
        logic [47:0] diag;
        int unsigned w;
        int turn;
        cmd_t c;
        diag = 48'(s.slant) * 48'(DIAG_NUM);
        w = wall_dist;
        turn = 0;
        c = '0;
        case (ctl_mode)
            MODE_APPROACH:
            begin
                if (s.front <= w)
                    ctl_mode = MODE_ROTATE;
                else
                    c.speed = cruise;
            end
            MODE_ROTATE:
            begin
                if (abs_gap(diag, 48'(s.right) << FRAC_SHIFT) < (48'(align_tol) << FRAC_SHIFT)
                    && s.front >= w)
                    ctl_mode = MODE_FOLLOW;
                else
                    turn = 1;
            end
            MODE_FOLLOW:
            begin
                if (s.front <= w) begin
                    ctl_mode = MODE_ROTATE;
                end else if (s.right > w + w / 10) begin
                    back_mark = s.back;
                    ctl_mode = MODE_CORNER;
                end else begin
                    c.speed = cruise;
                end
            end
            default:
            begin
                if (back_mark != '0 && w > HOLD_MARGIN_MM
                    && abs_gap(48'(s.back), 48'(back_mark)) < 48'(w - HOLD_MARGIN_MM)) begin
                    c.speed = cruise;
                end else begin
                    back_mark = '0;
                    if (diag > (48'(w) << FRAC_SHIFT))
                        turn = -1;
                    else if (s.right > w)
                        c.speed = cruise;
                    else
                        ctl_mode = MODE_FOLLOW;
                end
            end
        endcase
        if (turn > 0)
            c.angular = ang_t'({1'b0, turn_rt});
        else if (turn < 0)
            c.angular = -ang_t'({1'b0, turn_rt});
        c.mode = ctl_mode;
        return c;
    endfunction

    function automatic dist_t near(input int center, input int span);
        int v;
        v = center + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return dist_t'(v);
    endfunction

    function automatic dist_t any_range();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0)
            return '1;
        if (pick == 1)
            return dist_t'($urandom_range(0, 15));
        return dist_t'($urandom);
    endfunction

    // Mostly steers toward the current mode's decision points; the rest is noise.
    function automatic scan_t make_scan();
        scan_t s;
        int w;
        int proj;
        w = wall_dist;
        s.front = any_range();
        s.slant = any_range();
        s.right = any_range();
        s.back = any_range();
        if ($urandom_range(0, 4) != 0) begin
            case (ctl_mode)
                MODE_APPROACH:
                begin
                    if ($urandom_range(0, 1) == 0)
                        s.front = near(w, 40);
                end
                MODE_ROTATE:
                begin
                    s.slant = dist_t'($urandom_range(0, 6000));
                    proj = (int'(s.slant) * int'(DIAG_NUM)) >>> FRAC_SHIFT;
                    s.right = near(proj, int'(align_tol) + 3);
                    if ($urandom_range(0, 3) == 0)
                        s.front = near(w, 20);
                    else
                        s.front = dist_t'($urandom_range(w, 65535));
                end
                MODE_FOLLOW:
                begin
                    if ($urandom_range(0, 7) == 0)
                        s.front = near(w, 20);
                    else
                        s.front = dist_t'($urandom_range(w + 1, 65535));
                    s.right = near(w + w / 10, 60);
                    if ($urandom_range(0, 5) == 0)
                        s.back = '0;
                end
                default:
                begin
                    if (back_mark != '0 && $urandom_range(0, 3) != 0)
                        s.back = near(back_mark, w);
                    // w * sqrt(2): diagonal range that projects onto w
                    s.slant = near((w * 92682) >>> 16, 40);
                    s.right = near(w, 40);
                end
            endcase
        end
        return s;
    endfunction

    task automatic send_scan(input scan_t s, input logic typed, input cmd_t want);
        int gap;
        cmd_t c;
        gap = idle_in ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        front_mm       <= s.front;
        front_right_mm <= s.slant;
        right_mm       <= s.right;
        back_mm        <= s.back;
        do @(posedge clk); while (!in_ready);
        c = steer_step(s);
        cmd_fifo.push_back(typed ? want : c);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_WALL_DISTANCE: wall_dist = wall_t'(data);
            REG_ALIGN_TOL:     align_tol = tol_t'(data);
            REG_CRUISE_SPEED:  cruise = speed_t'(data);
            REG_TURN_RATE:     turn_rt = rate_t'(data);
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] t,
                                input logic [CFG_BITS-1:0] s, input logic [CFG_BITS-1:0] r);
        write_reg(REG_WALL_DISTANCE, w);
        // unmapped index; must leave every register alone
        write_reg(IDX_BITS'($urandom_range(4, 255)), CFG_BITS'($urandom));
        write_reg(REG_ALIGN_TOL, t);
        write_reg(REG_CRUISE_SPEED, s);
        write_reg(REG_TURN_RATE, r);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (cmd_fifo.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [CFG_BITS-1:0] pick_reg(input int lo, input int hi);
        if ($urandom_range(0, 4) == 0)
            return CFG_BITS'($urandom);
        return CFG_BITS'($urandom_range(lo, hi));
    endfunction

    // command channel: check each transfer, then stall a random number of cycles while idle_out is set
    always @(posedge clk) begin
        cmd_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (out_valid && out_ready) begin
            if (cmd_fifo.size() == 0) begin
                log_mismatch($sformatf("unexpected command speed=%0d rate=%0d mode=%0d",
                                       linear_speed, angular_rate, mode_after));
            end else begin
                want = cmd_fifo.pop_front();
                if (linear_speed !== want.speed)
                    log_mismatch($sformatf("linear_speed %0d, want %0d",
                                           linear_speed, want.speed));
                if (angular_rate !== want.angular)
                    log_mismatch($sformatf("angular_rate %0d, want %0d",
                                           angular_rate, want.angular));
                if (mode_after !== want.mode)
                    log_mismatch($sformatf("mode_after %0d, want %0d", mode_after, want.mode));
            end
            out_hold = idle_out ? $urandom_range(0, 9) : 0;
            out_ready <= (out_hold == 0);
        end else if (!out_ready) begin
            if (out_hold > 0)
                out_hold--;
            if (out_hold == 0)
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < N_ROWS; n++)
            send_scan(ROWS[n].scan, ROWS[n].typed, ROWS[n].want);
        in_valid <= 1'b0;
        drain();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: program_regs(16'd150, 16'd0, 16'd0, 16'd0);
                1: program_regs(16'd4000, 16'd1000, 16'd1000, 16'd6283);
                2: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                // small wall distance: corner hold threshold not positive
                3: program_regs(16'd100, 16'd50, 16'd300, 16'd1000);
                4: program_regs(16'd0, 16'd5, 16'd1, 16'd1);
                5: program_regs(16'd101, 16'd0, 16'd512, 16'd4096);
                default: program_regs(pick_reg(150, 4000), pick_reg(0, 1000),
                                      pick_reg(0, 1000), pick_reg(0, 6283));
            endcase
            idle_in  = ($urandom_range(0, 3) != 0);
            idle_out = ($urandom_range(0, 3) != 0);
            for (n = 0; n < SCANS_PER_PHASE; n++)
                send_scan(make_scan(), 1'b0, '0);
            in_valid <= 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/wfmc_pkg.sv
hw/rtl/wfmc_step.sv
hw/rtl/wall_follow_mode_controller.sv
tb/wall_follow_mode_controller_tb.sv
